@@ design/fpdf_pkg.sv @@
// shared types, constants and helpers of the fixed-point decimal formatter
package fpdf_pkg;

   localparam int MAX_CHARS  = 12;
   localparam int FRAC_MAX   = 9;
   localparam int MAX_DIGITS = 10;
   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int DIGIT_W    = 4;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int LEN_W      = $clog2(MAX_CHARS + 2) + 1;

   localparam logic [CFG_W-1:0]  RST_FIELD_WIDTH = CFG_W'(12);
   localparam logic [CFG_W-1:0]  RST_FRAC_DIGITS = CFG_W'(1);
   localparam logic [CHAR_W-1:0] RST_POS_CHAR    = CHAR_W'(32);
   localparam logic [CHAR_W-1:0] RST_NEG_CHAR    = CHAR_W'(45);

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_N     = 8'h4e;
   localparam logic [CHAR_W-1:0] CH_A     = 8'h41;

   // floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
   localparam logic [VALUE_W-1:0] RECIP10       = 32'hcccc_cccd;
   localparam int                 RECIP10_SHIFT = 35;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_WIDTH = 2'd0,
      CSR_FRAC_DIGITS = 2'd1,
      CSR_POS_CHAR    = 2'd2,
      CSR_NEG_CHAR    = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CONV = 2'd1,
      ST_EMIT = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic out_free;
      logic emit_last;
   } ctl_sts_type;

   function automatic logic [CHAR_W-1:0] nan_char(input logic [1:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         2'd0:    ch = CH_PLUS;
         2'd1:    ch = CH_N;
         2'd2:    ch = CH_A;
         default: ch = CH_N;
      endcase
      return ch;
   endfunction

endpackage

@@ design/fpdf_ctrl.sv @@
// controller state machine: accept, digit conversion, character emission
module fpdf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fpdf_pkg::ctl_sts_type sts,
   output fpdf_pkg::ctl_cmd_type cmd
);

   fpdf_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpdf_pkg::ST_IDLE: begin
            if (req_valid) state_in = fpdf_pkg::ST_CONV;
         end
         fpdf_pkg::ST_CONV: begin
            if (sts.conv_done) state_in = fpdf_pkg::ST_EMIT;
         end
         fpdf_pkg::ST_EMIT: begin
            if (sts.out_free && sts.emit_last) state_in = fpdf_pkg::ST_IDLE;
         end
         default: state_in = fpdf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         fpdf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         fpdf_pkg::ST_CONV: begin
            cmd.conv_step = 1'b1;
         end
         fpdf_pkg::ST_EMIT: begin
            cmd.emit_step = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ design/fpdf_dpath.sv @@
// datapath: settings, digit extraction, digit store and character output register
module fpdf_dpath (
   input  logic                                       clock,
   input  logic                                       reset,
   input  fpdf_pkg::ctl_cmd_type                      cmd,
   output fpdf_pkg::ctl_sts_type                      sts,
   input  logic                                       csr_valid,
   input  logic [fpdf_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [fpdf_pkg::CSR_DATA_W-1:0]            csr_data,
   input  logic signed [fpdf_pkg::VALUE_W-1:0]        req_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [fpdf_pkg::CHAR_W-1:0]                rsp_text_char,
   output logic                                       rsp_last_char,
   output logic                                       rsp_overflowed
);

   localparam int VW = fpdf_pkg::VALUE_W;
   localparam int CW = fpdf_pkg::CHAR_W;
   localparam int FW = fpdf_pkg::CFG_W;
   localparam int LW = fpdf_pkg::LEN_W;
   localparam int NW = fpdf_pkg::CNT_W;
   localparam int DW = fpdf_pkg::DIGIT_W;
   localparam int ND = fpdf_pkg::MAX_DIGITS;

   // settings
   logic [FW-1:0] width_cfg_ff, frac_cfg_ff;
   logic [CW-1:0] pos_char_ff, neg_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff <= fpdf_pkg::RST_FIELD_WIDTH;
         frac_cfg_ff  <= fpdf_pkg::RST_FRAC_DIGITS;
         pos_char_ff  <= fpdf_pkg::RST_POS_CHAR;
         neg_char_ff  <= fpdf_pkg::RST_NEG_CHAR;
      end else if (csr_valid) begin
         unique case (fpdf_pkg::csr_idx_type'(csr_index))
            fpdf_pkg::CSR_FIELD_WIDTH: width_cfg_ff <= csr_data[FW-1:0];
            fpdf_pkg::CSR_FRAC_DIGITS: frac_cfg_ff  <= csr_data[FW-1:0];
            fpdf_pkg::CSR_POS_CHAR:    pos_char_ff  <= csr_data;
            fpdf_pkg::CSR_NEG_CHAR:    neg_char_ff  <= csr_data;
            default:                   width_cfg_ff <= width_cfg_ff;
         endcase
      end
   end

   logic [LW-1:0] width_eff;
   logic [FW-1:0] frac_eff;
   logic          left_mode;

   always_comb begin
      priority if (width_cfg_ff == '0) width_eff = LW'(1);
      else if (LW'(width_cfg_ff) > LW'(fpdf_pkg::MAX_CHARS)) width_eff = LW'(fpdf_pkg::MAX_CHARS);
      else width_eff = LW'(width_cfg_ff);
      priority if (frac_cfg_ff == '0) frac_eff = FW'(1);
      else if (frac_cfg_ff > FW'(fpdf_pkg::FRAC_MAX)) frac_eff = FW'(fpdf_pkg::FRAC_MAX);
      else frac_eff = frac_cfg_ff;
      left_mode = (pos_char_ff == fpdf_pkg::CH_SPACE);
   end

   // digit extraction, one digit per cycle
   logic [VW-1:0]   mag_ff;
   logic            neg_ff;
   logic [NW-1:0]   ndig_ff, rd_ff;
   logic [DW-1:0]   dig_ff [ND];
   logic            pend_ff, pt_ff;
   logic [LW-1:0]   pos_ff;

   logic [2*VW-1:0] prod;
   logic [VW-1:0]   quot, quot10, rem;

   always_comb begin
      prod   = (2*VW)'(mag_ff) * (2*VW)'(fpdf_pkg::RECIP10);
      quot   = VW'(prod[2*VW-1:fpdf_pkg::RECIP10_SHIFT]);
      quot10 = (quot << 3) + (quot << 1);
      rem    = mag_ff - quot10;
   end

   // field layout
   logic [LW-1:0] txt_len, need, lead;
   logic          ovf, in_text, last_col;

   always_comb begin
      txt_len  = LW'(ndig_ff) + LW'(1) + LW'(left_mode && neg_ff);
      need     = txt_len + LW'(!left_mode);
      ovf      = need > width_eff;
      lead     = left_mode ? '0 : (width_eff - txt_len);
      in_text  = pos_ff >= lead;
      last_col = pos_ff == (width_eff - LW'(1));
   end

   logic [CW-1:0] ch;
   logic          take_pend, take_pt, take_dig;

   always_comb begin
      ch        = fpdf_pkg::CH_SPACE;
      take_pend = 1'b0;
      take_pt   = 1'b0;
      take_dig  = 1'b0;
      priority if (ovf) begin
         if (pos_ff < LW'(4)) ch = fpdf_pkg::nan_char(pos_ff[1:0]);
      end else if (!left_mode && pos_ff == '0) begin
         ch = neg_ff ? neg_char_ff : pos_char_ff;
      end else if (!in_text) begin
         ch = fpdf_pkg::CH_SPACE;
      end else if (pend_ff) begin
         ch        = neg_char_ff;
         take_pend = 1'b1;
      end else if (FW'(rd_ff) == frac_eff && !pt_ff) begin
         ch      = fpdf_pkg::CH_POINT;
         take_pt = 1'b1;
      end else if (rd_ff != '0) begin
         ch       = fpdf_pkg::CH_ZERO + CW'(dig_ff[0]);
         take_dig = 1'b1;
      end else begin
         ch = fpdf_pkg::CH_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[VW-1];
         mag_ff <= req_value[VW-1] ? (VW'(0) - VW'(req_value)) : VW'(req_value);
      end else if (cmd.conv_step) begin
         mag_ff <= quot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.conv_step) begin
         dig_ff[0] <= rem[DW-1:0];
         for (int i = 1; i < ND; i++) dig_ff[i] <= dig_ff[i-1];
      end else if (cmd.emit_step && take_dig) begin
         for (int i = 0; i < ND - 1; i++) dig_ff[i] <= dig_ff[i+1];
         dig_ff[ND-1] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff <= '0;
         rd_ff   <= '0;
         pend_ff <= 1'b0;
         pt_ff   <= 1'b0;
         pos_ff  <= '0;
      end else if (cmd.load) begin
         ndig_ff <= '0;
         rd_ff   <= '0;
         pend_ff <= left_mode && req_value[VW-1];
         pt_ff   <= 1'b0;
         pos_ff  <= '0;
      end else if (cmd.conv_step) begin
         ndig_ff <= ndig_ff + NW'(1);
         rd_ff   <= ndig_ff + NW'(1);
      end else if (cmd.emit_step) begin
         pos_ff <= pos_ff + LW'(1);
         if (take_pend) pend_ff <= 1'b0;
         if (take_pt) pt_ff <= 1'b1;
         if (take_dig) rd_ff <= rd_ff - NW'(1);
      end
   end

   // output register
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_char_ff;
   logic          rsp_last_ff, rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         rsp_char_ff <= ch;
         rsp_last_ff <= last_col;
         rsp_ovf_ff  <= ovf;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_char  = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   always_comb begin
      sts.conv_done = (FW'(ndig_ff) >= frac_eff) && (quot == '0);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
      sts.emit_last = last_col;
   end

endmodule

@@ design/fixed_point_decimal_formatter.sv @@
// top level of the fixed-point decimal formatter
//
//  channel   ports                                     handshake
//  req       req_value                                 req_valid / req_stall
//  rsp       rsp_text_char rsp_last_char rsp_overflowed rsp_valid / rsp_stall
//  csr       csr_index csr_data                        csr_valid / csr_ready
//
// an item is accepted, then converted one decimal digit per cycle through the
// shared divide-by-ten multiplier (max(frac_digits+1, digit count), at most 10),
// then its field_width characters go out through the character output register
// reset restores field_width 12, frac_digits 1, positive char space, negative char '-'
// rsp_stall holds the output register and pauses emission; the next item is
// accepted once the last character is in the output register
module fixed_point_decimal_formatter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fpdf_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fpdf_pkg::CHAR_W-1:0]          rsp_text_char,
   output logic                                 rsp_last_char,
   output logic                                 rsp_overflowed,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fpdf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpdf_pkg::CSR_DATA_W-1:0]      csr_data
);

   fpdf_pkg::ctl_cmd_type cmd;
   fpdf_pkg::ctl_sts_type sts;

   assign csr_ready = 1'b1;

   fpdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fpdf_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_last_char  (rsp_last_char),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

@@ design/fpdf_checker.sv @@
// port-level assertions of the formatter and their bind
module fpdf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [fpdf_pkg::CHAR_W-1:0]     rsp_text_char,
   input logic                            rsp_last_char,
   input logic                            rsp_overflowed,
   input logic                            csr_valid,
   input logic                            csr_ready
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_char)
         && $stable(rsp_last_char) && $stable(rsp_overflowed))
      else $error("stalled rsp item changed");

   // busy right after an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req not stalled after accept");

   // stall only rises because an item was taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("req_stall rose without an accepted item");

   // settings port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write not taken");

endmodule

bind fixed_point_decimal_formatter fpdf_checker u_fpdf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_text_char  (rsp_text_char),
   .rsp_last_char  (rsp_last_char),
   .rsp_overflowed (rsp_overflowed),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);
